/* sv/amtl_pkg.sv */
// shared types and constants for the adjacency matrix text loader
`timescale 1ns / 1ps

package amtl_pkg;

	// field widths of the item channels
	localparam int OP_W         = 2;
	localparam int BYTE_W       = 8;
	localparam int NODE_TOTAL_W = 7;
	localparam int EDGE_TOTAL_W = 12;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} amtl_op_t;

	// characters the parser reacts to
	localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;

endpackage

/* sv/amtl_ifs.sv */
// command and response channel interfaces of the adjacency matrix text loader
`timescale 1ns / 1ps

interface amtl_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [amtl_pkg::OP_W-1:0]     operation;
	logic [amtl_pkg::BYTE_W-1:0]   text_byte;
	logic [amtl_pkg::BYTE_W-1:0]   first_node;
	logic [amtl_pkg::BYTE_W-1:0]   second_node;

	modport source (output valid, operation, text_byte, first_node, second_node, input ready);
	modport sink (input valid, operation, text_byte, first_node, second_node, output ready);
endinterface

interface amtl_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                edge_present;
	logic [amtl_pkg::NODE_TOTAL_W-1:0]   node_total;
	logic [amtl_pkg::EDGE_TOTAL_W-1:0]   edge_total;
	logic                                load_ended;
	logic                                too_wide;

	modport source (output valid, edge_present, node_total, edge_total, load_ended, too_wide,
		input ready);
	modport sink (input valid, edge_present, node_total, edge_total, load_ended, too_wide,
		output ready);
endinterface

/* sv/adjacency_matrix_text_loader.sv */
// top level: text adjacency matrix loader with edge queries
`timescale 1ns / 1ps

// channel | dir | fields
// --------+-----+-------------------------------------------------------------
// cmd     | in  | operation, text_byte, first_node, second_node
// rsp     | out | edge_present, node_total, edge_total, load_ended, too_wide
//
// one item per cycle sustained while the receiver takes each result; an item passes
// the input register, then the row memory read and the result register
// the row memory has one write port (current row) and one read port (query row)
// reset needs no clearing pass: per-row valid bits hide rows of earlier loads
// a stalled result holds the input register, and the port takes a new item only
// when the input register moves on or is empty

module adjacency_matrix_text_loader #(
	parameter int MAX_NODES = 64
) (
	input logic          clk,
	input logic          arst_n,
	amtl_cmd_if.sink     cmd,
	amtl_rsp_if.source   rsp
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int ONES_W = $clog2(MAX_NODES * MAX_NODES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);

	// input register
	logic                          valid_s1;
	amtl_pkg::amtl_op_t            op_s1;
	logic [amtl_pkg::BYTE_W-1:0]   byte_s1;
	logic [amtl_pkg::BYTE_W-1:0]   n1_s1;
	logic [amtl_pkg::BYTE_W-1:0]   n2_s1;

	// result register
	logic                   valid_s2;
	logic                   hit_s2;
	logic                   use_buf_s2;
	logic                   buf_bit_s2;
	logic                   row_ok_s2;
	logic [IDX_W-1:0]       col_s2;
	logic [MAX_NODES-1:0]   row_s2;

	// load state
	logic                   first_open_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   wide_q;
	logic                   ended_q;
	logic [CNT_W-1:0]       row_q;
	logic [CNT_W-1:0]       col_q;
	logic [ONES_W-1:0]      ones_q;
	logic [MAX_NODES-1:0]   buf_q;
	logic [MAX_NODES-1:0]   row_valid_q;
	logic [MAX_NODES-1:0]   rows_q [MAX_NODES];

	logic                   first_open_d;
	logic [CNT_W-1:0]       cnt_d;
	logic                   wide_d;
	logic                   ended_d;
	logic [CNT_W-1:0]       row_d;
	logic [CNT_W-1:0]       col_d;
	logic [ONES_W-1:0]      ones_d;
	logic [MAX_NODES-1:0]   buf_d;
	logic                   wr_en;

	logic adv;
	logic do_start;
	logic do_load;
	logic is_term;
	logic is_digit;
	logic is_one;
	logic q_hit;

	logic [IDX_W-1:0] row_idx;
	logic [IDX_W-1:0] col_idx;
	logic [IDX_W-1:0] n1_idx;
	logic [IDX_W-1:0] n2_idx;

	// handshake
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign rsp.valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input payload capture
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= amtl_pkg::amtl_op_t'(cmd.operation);
			byte_s1 <= cmd.text_byte;
			n1_s1   <= cmd.first_node;
			n2_s1   <= cmd.second_node;
		end
	end

	// byte classes and indexes
	assign do_start = adv && (op_s1 == amtl_pkg::OP_START);
	assign do_load  = adv && (op_s1 == amtl_pkg::OP_LOAD) && !ended_q;
	assign is_term  = (byte_s1 == amtl_pkg::CH_NL) || (byte_s1 == amtl_pkg::CH_CR)
		|| (byte_s1 == amtl_pkg::CH_DASH);
	assign is_one   = (byte_s1 == amtl_pkg::CH_ONE);
	assign is_digit = is_one || (byte_s1 == amtl_pkg::CH_ZERO);
	assign row_idx  = row_q[IDX_W-1:0];
	assign col_idx  = col_q[IDX_W-1:0];
	assign n1_idx   = n1_s1[IDX_W-1:0];
	assign n2_idx   = n2_s1[IDX_W-1:0];

	// parser next state
	always_comb begin
		first_open_d = first_open_q;
		cnt_d        = cnt_q;
		wide_d       = wide_q;
		ended_d      = ended_q;
		row_d        = row_q;
		col_d        = col_q;
		ones_d       = ones_q;
		buf_d        = buf_q;
		wr_en        = 1'b0;
		if (do_start) begin
			first_open_d = 1'b1;
			cnt_d        = '0;
			wide_d       = 1'b0;
			ended_d      = 1'b0;
			row_d        = '0;
			col_d        = '0;
			ones_d       = '0;
			buf_d        = '0;
		end else if (do_load) begin
			// first line sets the node count
			if (first_open_q) begin
				if (is_term) begin
					first_open_d = 1'b0;
				end else if (cnt_q < CNT_MAX) begin
					cnt_d = cnt_q + CNT_W'(1);
				end else begin
					wide_d = 1'b1;
				end
			end
			if (byte_s1 == amtl_pkg::CH_DASH) begin
				ended_d = 1'b1;
			end else if (is_digit) begin
				if ((row_q < cnt_d) && (col_q < cnt_d)) begin
					wr_en          = 1'b1;
					buf_d[col_idx] = is_one;
					ones_d         = ones_q + ONES_W'(is_one);
				end
				if (col_q < CNT_MAX) begin
					col_d = col_q + CNT_W'(1);
				end
			end else if (byte_s1 == amtl_pkg::CH_NL) begin
				// a newline closes only a row that held digits
				if (col_q != '0) begin
					if (row_q < CNT_MAX) begin
						row_d = row_q + CNT_W'(1);
					end
					col_d = '0;
					buf_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_open_q <= 1'b1;
			cnt_q        <= '0;
			wide_q       <= 1'b0;
			ended_q      <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			ones_q       <= '0;
			buf_q        <= '0;
			row_valid_q  <= '0;
		end else begin
			first_open_q <= first_open_d;
			cnt_q        <= cnt_d;
			wide_q       <= wide_d;
			ended_q      <= ended_d;
			row_q        <= row_d;
			col_q        <= col_d;
			ones_q       <= ones_d;
			buf_q        <= buf_d;
			if (do_start) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[row_idx] <= 1'b1;
			end
		end
	end

	// query: the row being built lives in the buffer, finished rows in memory
	assign q_hit = (op_s1 == amtl_pkg::OP_QUERY)
		&& (n1_s1 < amtl_pkg::BYTE_W'(cnt_q)) && (n2_s1 < amtl_pkg::BYTE_W'(cnt_q));

	// row memory and result capture
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_q[row_idx] <= buf_d;
		end
		if (adv) begin
			row_s2     <= rows_q[n1_idx];
			hit_s2     <= q_hit;
			use_buf_s2 <= (n1_s1 == amtl_pkg::BYTE_W'(row_q));
			buf_bit_s2 <= buf_q[n2_idx];
			row_ok_s2  <= row_valid_q[n1_idx];
			col_s2     <= n2_idx;
		end
	end

	// result fields; load state only moves when the result register loads
	assign rsp.edge_present = hit_s2 && (use_buf_s2 ? buf_bit_s2 : (row_ok_s2 && row_s2[col_s2]));
	assign rsp.node_total   = amtl_pkg::NODE_TOTAL_W'(cnt_q);
	assign rsp.edge_total   = amtl_pkg::EDGE_TOTAL_W'(ones_q >> 1);
	assign rsp.load_ended   = ended_q;
	assign rsp.too_wide     = wide_q;

endmodule

/* sv/amtl_checker.sv */
// port-level checks for the adjacency matrix text loader, bound to the top level
`timescale 1ns / 1ps

module amtl_checker #(
	parameter int MAX_NODES = 64
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cmd_valid,
	input logic                                 cmd_ready,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic                                 edge_present,
	input logic [amtl_pkg::NODE_TOTAL_W-1:0]    node_total,
	input logic [amtl_pkg::EDGE_TOTAL_W-1:0]    edge_total,
	input logic                                 load_ended,
	input logic                                 too_wide
);

	// a stalled result keeps its fields
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(edge_present) && $stable(node_total)
			&& $stable(edge_total) && $stable(load_ended) && $stable(too_wide))
		else $error("result changed while stalled");

	// a fresh result follows an item taken in through the input register
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result without a preceding item");

	// the input side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid)
		else $error("input stalled with no result waiting");

	// an overlong first line leaves the node count at its limit
	a_wide_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && too_wide |-> node_total == amtl_pkg::NODE_TOTAL_W'(MAX_NODES))
		else $error("too_wide with node count below limit");

endmodule

bind adjacency_matrix_text_loader amtl_checker #(.MAX_NODES(MAX_NODES)) u_amtl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.edge_present (rsp.edge_present),
	.node_total   (rsp.node_total),
	.edge_total   (rsp.edge_total),
	.load_ended   (rsp.load_ended),
	.too_wide     (rsp.too_wide)
);

/* bench/adjacency_matrix_text_loader_tb.sv */
// testbench for the adjacency matrix text loader: text matrices in, load status checked per item
`timescale 1ns / 1ps

module adjacency_matrix_text_loader_tb;

	localparam int NODES_MAX  = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_GOAL  = 500;
	localparam int LEAD_ITEMS = 25;
	localparam logic [amtl_pkg::BYTE_W-1:0] CH_OTHER = 8'h78;

	typedef struct packed {
		logic                              edge_present;
		logic [amtl_pkg::NODE_TOTAL_W-1:0] node_total;
		logic [amtl_pkg::EDGE_TOTAL_W-1:0] edge_total;
		logic                              load_ended;
		logic                              too_wide;
	} loader_status_t;

	// mirror of the loader state and the queue of status items still due
	class matrix_tracker;
		bit [NODES_MAX-1:0] rows [NODES_MAX];
		bit [NODES_MAX-1:0] row_live;
		bit [NODES_MAX-1:0] ever_written;
		bit [6:0]           node_count;
		bit                 first_line;
		bit [6:0]           row_idx;
		bit [6:0]           col_idx;
		bit [12:0]          ones;
		bit                 ended;
		bit                 wide;
		loader_status_t     status_due[$];
		int                 errors;

		function new();
			ever_written = '0;
			errors = 0;
			clear_load();
		endfunction

		// a new load hides all rows through their valid bits
		function void clear_load();
			row_live   = '0;
			node_count = '0;
			first_line = 1'b1;
			row_idx    = '0;
			col_idx    = '0;
			ones       = '0;
			ended      = 1'b0;
			wide       = 1'b0;
		endfunction

		function void parse_byte(logic [amtl_pkg::BYTE_W-1:0] b);
			if (ended)
				return;
			// first line sets the node count
			if (first_line) begin
				if (b == amtl_pkg::CH_NL || b == amtl_pkg::CH_CR || b == amtl_pkg::CH_DASH)
					first_line = 1'b0;
				else if (node_count < NODES_MAX)
					node_count++;
				else
					wide = 1'b1;
			end
			if (b == amtl_pkg::CH_DASH) begin
				ended = 1'b1;
			end else if (b == amtl_pkg::CH_ZERO || b == amtl_pkg::CH_ONE) begin
				// store inside the square only, first write clears the row
				if (row_idx < node_count && col_idx < node_count) begin
					if (!row_live[row_idx[5:0]]) begin
						rows[row_idx[5:0]] = '0;
						row_live[row_idx[5:0]] = 1'b1;
						ever_written[row_idx[5:0]] = 1'b1;
					end
					rows[row_idx[5:0]][col_idx[5:0]] = (b == amtl_pkg::CH_ONE);
					if (b == amtl_pkg::CH_ONE)
						ones++;
				end
				if (col_idx < NODES_MAX)
					col_idx++;
			end else if (b == amtl_pkg::CH_NL && col_idx != 0) begin
				// newline only ends a row that held digits
				if (row_idx < NODES_MAX)
					row_idx++;
				col_idx = '0;
			end
		endfunction

		function void take_item(amtl_pkg::amtl_op_t op, logic [amtl_pkg::BYTE_W-1:0] b,
			logic [amtl_pkg::BYTE_W-1:0] n1, logic [amtl_pkg::BYTE_W-1:0] n2);
			loader_status_t s;
			s.edge_present = 1'b0;
			case (op)
				amtl_pkg::OP_START: clear_load();
				amtl_pkg::OP_LOAD:  parse_byte(b);
				amtl_pkg::OP_QUERY: begin
					if (n1 < node_count && n2 < node_count)
						s.edge_present = row_live[n1[5:0]] && rows[n1[5:0]][n2[5:0]];
				end
				default: ;
			endcase
			s.node_total = node_count;
			s.edge_total = ones[12:1];
			s.load_ended = ended;
			s.too_wide   = wide;
			status_due.push_back(s);
		endfunction

		function string show(loader_status_t s);
			return $sformatf("edge=%0d nodes=%0d edges=%0d ended=%0d wide=%0d",
				s.edge_present, s.node_total, s.edge_total, s.load_ended, s.too_wide);
		endfunction

		function void check_status(loader_status_t got);
			loader_status_t want;
			if (status_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = status_due.pop_front();
			if (got.edge_present !== want.edge_present || got.node_total !== want.node_total ||
				got.edge_total !== want.edge_total || got.load_ended !== want.load_ended ||
				got.too_wide !== want.too_wide) begin
				errors++;
				if (errors <= 10)
					$display("status mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	amtl_cmd_if cmd_bus ();
	amtl_rsp_if rsp_bus ();

	matrix_tracker tracker;
	int send_idle_pct  = 11;
	int recv_stall_pct = 58;
	int items_done     = 0;
	int idle_cycles;

	adjacency_matrix_text_loader #(.MAX_NODES(NODES_MAX)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			tracker.check_status(loader_status_t'({rsp_bus.edge_present, rsp_bus.node_total,
				rsp_bus.edge_total, rsp_bus.load_ended, rsp_bus.too_wide}));
	end

	// watchdog on cycles without any handshake
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
				(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// random byte value
	function automatic logic [amtl_pkg::BYTE_W-1:0] rand_byte();
		return amtl_pkg::BYTE_W'($urandom_range(255));
	endfunction

	// one item through the command port, entered and left at a falling edge
	task automatic send_item(amtl_pkg::amtl_op_t op, logic [amtl_pkg::BYTE_W-1:0] b,
		logic [amtl_pkg::BYTE_W-1:0] n1, logic [amtl_pkg::BYTE_W-1:0] n2);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.operation   <= op;
		cmd_bus.text_byte   <= b;
		cmd_bus.first_node  <= n1;
		cmd_bus.second_node <= n2;
		@(posedge clk);
		while (cmd_bus.ready !== 1'b1)
			@(posedge clk);
		if (op == amtl_pkg::OP_START || op == amtl_pkg::OP_QUERY ||
			(op == amtl_pkg::OP_LOAD && !tracker.ended))
			items_done++;
		tracker.take_item(op, b, n1, n2);
		@(negedge clk);
	endtask

	task automatic send_byte(logic [amtl_pkg::BYTE_W-1:0] b);
		send_item(amtl_pkg::OP_LOAD, b, rand_byte(), rand_byte());
	endtask

	task automatic send_query(logic [amtl_pkg::BYTE_W-1:0] n1, logic [amtl_pkg::BYTE_W-1:0] n2);
		send_item(amtl_pkg::OP_QUERY, rand_byte(), n1, n2);
	endtask

	// query near the node count, never an in-range row that was never stored
	task automatic random_query();
		logic [amtl_pkg::BYTE_W-1:0] r;
		logic [amtl_pkg::BYTE_W-1:0] c;
		int top;
		top = tracker.node_count;
		if ($urandom_range(4) == 0) begin
			r = rand_byte();
			c = rand_byte();
		end else begin
			r = amtl_pkg::BYTE_W'($urandom_range(top));
			c = amtl_pkg::BYTE_W'($urandom_range(top));
		end
		if (r < top && c < top && !tracker.ever_written[r[5:0]])
			r = amtl_pkg::BYTE_W'(top);
		send_query(r, c);
	endtask

	// hold the sender until every status item has come back
	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (tracker.status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// reset, directed cases, then random matrices in three idling phases
	initial begin
		int n;
		int rows_out;
		int width;
		int ones_pct;
		int r;
		int c;
		bit big_done;
		tracker = new();
		big_done = 1'b0;
		arst_n = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.operation   = amtl_pkg::OP_NONE;
		cmd_bus.text_byte   = '0;
		cmd_bus.first_node  = '0;
		cmd_bus.second_node = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// status after reset and the unused operation
		send_query(8'd0, 8'd0);
		send_item(amtl_pkg::OP_NONE, 8'hFF, 8'hFF, 8'hFF);
		// end marker on an empty first line, later bytes ignored
		send_item(amtl_pkg::OP_START, 8'h00, 8'h00, 8'h00);
		send_byte(amtl_pkg::CH_DASH);
		send_byte(amtl_pkg::CH_ONE);
		// empty first line by newline leaves nothing stored
		send_item(amtl_pkg::OP_START, 8'h00, 8'h00, 8'h00);
		send_byte(amtl_pkg::CH_NL);
		send_byte(amtl_pkg::CH_ONE);
		send_query(8'd0, 8'd0);
		// other bytes count on the first line, carriage return closes it
		send_item(amtl_pkg::OP_START, 8'h00, 8'h00, 8'h00);
		send_byte(amtl_pkg::CH_ONE);
		send_byte(amtl_pkg::CH_ZERO);
		send_byte(CH_OTHER);
		send_byte(amtl_pkg::CH_ONE);
		send_byte(amtl_pkg::CH_CR);
		send_byte(amtl_pkg::CH_NL);
		send_byte(amtl_pkg::CH_NL);
		// second row with one digit past the node count
		send_byte(amtl_pkg::CH_ZERO);
		repeat (4) send_byte(amtl_pkg::CH_ONE);
		send_byte(amtl_pkg::CH_NL);
		send_query(8'd0, 8'd2);
		send_query(8'd1, 8'd1);
		send_query(8'd1, 8'd4);
		send_query(8'd255, 8'd0);
		send_query(8'd0, 8'd255);
		send_byte(amtl_pkg::CH_DASH);
		send_byte(amtl_pkg::CH_ONE);
		send_query(8'd1, 8'd3);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 11;
					recv_stall_pct = 58;
				end
				1: begin
					send_idle_pct  = 58;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			while (items_done < LEAD_ITEMS + ITEM_GOAL * (ph + 1) / 3) begin
				// pick a size: mostly small, now and then past the node limit
				if (!big_done || $urandom_range(99) < 3) begin
					n = $urandom_range(60, 70);
					rows_out = $urandom_range(1, 3);
					big_done = 1'b1;
				end else begin
					n = ($urandom_range(99) < 12) ? $urandom_range(9, 20) : $urandom_range(1, 8);
					rows_out = n;
					if ($urandom_range(9) == 0)
						rows_out++;
					if ($urandom_range(9) == 0)
						rows_out--;
				end
				ones_pct = $urandom_range(100);
				if ($urandom_range(9) != 0)
					send_item(amtl_pkg::OP_START, rand_byte(), rand_byte(), rand_byte());
				// rows of digits with rare stray bytes
				for (r = 0; r < rows_out; r++) begin
					width = n + (($urandom_range(19) == 0) ? 1 : 0);
					for (c = 0; c < width; c++) begin
						if ($urandom_range(29) == 0)
							send_byte(rand_byte());
						send_byte(($urandom_range(99) < ones_pct) ? amtl_pkg::CH_ONE
							: amtl_pkg::CH_ZERO);
					end
					case ($urandom_range(9))
						0, 1: begin
							send_byte(amtl_pkg::CH_CR);
							send_byte(amtl_pkg::CH_NL);
						end
						2: begin
							send_byte(amtl_pkg::CH_NL);
							send_byte(amtl_pkg::CH_NL);
						end
						default: send_byte(amtl_pkg::CH_NL);
					endcase
					if ($urandom_range(3) == 0)
						random_query();
				end
				if ($urandom_range(3) != 0)
					send_byte(amtl_pkg::CH_DASH);
				if ($urandom_range(4) == 0)
					send_byte(rand_byte());
				if ($urandom_range(9) == 0)
					send_item(amtl_pkg::OP_NONE, rand_byte(), rand_byte(), rand_byte());
				repeat ($urandom_range(1, 5)) random_query();
			end
			drain();
		end

		if (tracker.errors == 0 && tracker.status_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
